// ----- design/gvsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gvsp_pkg
// Shared types and codes for the generational voice slot pool.
// ----------------------------------------------------------------------------
package gvsp_pkg;

  localparam int NUM_SLOTS = 32;

  // request modes
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_STOP    = 3'd1;
  localparam logic [2:0] MODE_STOP_CL = 3'd2;
  localparam logic [2:0] MODE_STOP_ALL = 3'd3;
  localparam logic [2:0] MODE_QUERY   = 3'd4;
  localparam logic [2:0] MODE_RECYCLE = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  localparam logic [15:0] GEN_FIRST = 16'h0001;
  localparam logic [15:0] GEN_LAST  = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] handle;
    logic [31:0] tag;
    logic        loop;
    logic        once;
    logic        ended;
  } req_t;

  typedef struct packed {
    logic        busy;
    logic        hit;      // handle resolves to this slot
    logic        claim;    // start takes this slot
    logic        freeing;  // this request frees the slot
    logic [15:0] gen;
  } cell_stat_t;

endpackage

// ----- design/gvsp_in_if.sv -----
// ----------------------------------------------------------------------------
// gvsp_in_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface gvsp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] handle_in;
  logic [31:0] clip_tag;
  logic        want_loop;
  logic        want_one_shot;
  logic        at_end;

  modport source (
    output valid, mode, handle_in, clip_tag, want_loop, want_one_shot, at_end,
    input  ready
  );
  modport sink (
    input  valid, mode, handle_in, clip_tag, want_loop, want_one_shot, at_end,
    output ready
  );
endinterface

// ----- design/gvsp_out_if.sv -----
// ----------------------------------------------------------------------------
// gvsp_out_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface gvsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] handle_out;
  logic        alive;
  logic [5:0]  freed_count;
  logic [5:0]  live_count;

  modport source (
    output valid, status, handle_out, alive, freed_count, live_count,
    input  ready
  );
  modport sink (
    input  valid, status, handle_out, alive, freed_count, live_count,
    output ready
  );
endinterface

// ----- design/gvsp_cell.sv -----
// ----------------------------------------------------------------------------
// gvsp_cell
// One voice slot: its record, generation and the free-slot search link.
// ----------------------------------------------------------------------------
module gvsp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         slot_pos,   // slot number plus one
  input  gvsp_pkg::req_t      req,
  input  logic                go,
  input  logic                claim_in,   // no free slot below this one
  output logic                claim_out,
  output gvsp_pkg::cell_stat_t stat
);

  logic        busy_r, busy_nxt;
  logic [15:0] gen_r, gen_nxt;
  logic [31:0] clip_r, clip_nxt;
  logic        loops_r, loops_nxt;
  logic        once_r, once_nxt;
  logic        hit, claim, freeing;

  assign hit = busy_r && (req.handle[15:0] == slot_pos) && (gen_r == req.handle[31:16]);
  assign claim     = claim_in && !busy_r && (req.mode == gvsp_pkg::MODE_START);
  assign claim_out = claim_in && busy_r;

  always_comb begin
    case (req.mode)
      gvsp_pkg::MODE_STOP:     freeing = hit;
      gvsp_pkg::MODE_STOP_CL:  freeing = busy_r && (clip_r == req.tag);
      gvsp_pkg::MODE_STOP_ALL: freeing = busy_r;
      gvsp_pkg::MODE_RECYCLE:  freeing = hit && once_r && !loops_r && req.ended;
      default:                 freeing = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    gen_nxt   = gen_r;
    clip_nxt  = clip_r;
    loops_nxt = loops_r;
    once_nxt  = once_r;
    if (go && claim) begin
      busy_nxt  = 1'b1;
      clip_nxt  = req.tag;
      loops_nxt = req.loop;
      once_nxt  = req.once;
    end else if (go && freeing) begin
      busy_nxt  = 1'b0;
      clip_nxt  = '0;
      loops_nxt = 1'b0;
      once_nxt  = 1'b0;
      // generation never wraps to zero
      gen_nxt   = (gen_r == gvsp_pkg::GEN_LAST) ? gvsp_pkg::GEN_FIRST : gen_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      gen_r   <= gvsp_pkg::GEN_FIRST;
      clip_r  <= '0;
      loops_r <= 1'b0;
      once_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      gen_r   <= gen_nxt;
      clip_r  <= clip_nxt;
      loops_r <= loops_nxt;
      once_r  <= once_nxt;
    end
  end

  always_comb begin
    stat.busy    = busy_r;
    stat.hit     = hit;
    stat.claim   = claim;
    stat.freeing = freeing;
    stat.gen     = gen_r;
  end

endmodule

// ----- design/generational_voice_slot_pool_top.sv -----
// ----------------------------------------------------------------------------
// generational_voice_slot_pool_top
// Voice slot pool with generation-tagged handles.
// ----------------------------------------------------------------------------
// Each request beat is captured in a request register, then every slot cell
// evaluates it in parallel and commits, writing the result register. A new
// request is taken once the previous one has been executed; execution waits
// only while an unread result still sits in the output register. There is no
// clearing pass: slot records reset at once. Handles are {generation,
// slot + 1}; generations start at 1 and skip 0.
module generational_voice_slot_pool_top (
  input  logic              clk,
  input  logic              rst_n,
  gvsp_in_if.sink           in_ch,
  gvsp_out_if.source        out_ch
);

  localparam int N = gvsp_pkg::NUM_SLOTS;

  gvsp_pkg::req_t       req_r, req_nxt;
  logic                 pending_r, pending_nxt;
  logic                 go;
  logic [N:0]           claim_chain;
  gvsp_pkg::cell_stat_t stat [N];

  logic [N-1:0] hit_v, claim_v, free_v;
  logic [31:0]  new_handle;
  logic         found, resolved;
  logic [5:0]   freed_cnt;
  logic [5:0]   live_r, live_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] hout_r, hout_nxt;
  logic        alive_r, alive_nxt;
  logic [5:0]  freed_r, freed_nxt;
  logic [5:0]  live_out_r;

  function automatic logic [5:0] pop_count(input logic [N-1:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < N; i++) c = c + 6'(v[i]);
    return c;
  endfunction

  // request capture
  assign in_ch.ready = !pending_r;
  assign go = pending_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    req_nxt     = req_r;
    pending_nxt = pending_r;
    if (in_ch.valid && in_ch.ready) begin
      req_nxt.mode   = in_ch.mode;
      req_nxt.handle = in_ch.handle_in;
      req_nxt.tag    = in_ch.clip_tag;
      req_nxt.loop   = in_ch.want_loop;
      req_nxt.once   = in_ch.want_one_shot;
      req_nxt.ended  = in_ch.at_end;
      pending_nxt    = 1'b1;
    end else if (go) begin
      pending_nxt = 1'b0;
    end
  end

  // cell row; the claim link picks the lowest free slot
  assign claim_chain[0] = 1'b1;

  for (genvar g = 0; g < N; g++) begin : g_cell
    gvsp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_pos  (16'(g + 1)),
      .req       (req_r),
      .go        (go),
      .claim_in  (claim_chain[g]),
      .claim_out (claim_chain[g+1]),
      .stat      (stat[g])
    );
    assign hit_v[g]   = stat[g].hit;
    assign claim_v[g] = stat[g].claim;
    assign free_v[g]  = stat[g].freeing;
  end

  always_comb begin
    new_handle = '0;
    for (int i = 0; i < N; i++) begin
      if (claim_v[i]) new_handle = {stat[i].gen, 16'(i + 1)};
    end
  end

  assign found     = |claim_v;
  assign resolved  = |hit_v;
  assign freed_cnt = pop_count(free_v);
  assign live_nxt  = live_r - freed_cnt + 6'(found);

  always_comb begin
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    alive_nxt     = alive_r;
    freed_nxt     = freed_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (go) begin
      out_valid_nxt = 1'b1;
      freed_nxt     = freed_cnt;
      if (req_r.mode == gvsp_pkg::MODE_START) begin
        status_nxt = found ? gvsp_pkg::ST_OK : gvsp_pkg::ST_FULL;
        hout_nxt   = new_handle;
        alive_nxt  = found;
      end else begin
        hout_nxt  = req_r.handle;
        alive_nxt = |(hit_v & ~free_v);
        if ((req_r.mode == gvsp_pkg::MODE_STOP || req_r.mode == gvsp_pkg::MODE_RECYCLE)
            && !resolved) begin
          status_nxt = gvsp_pkg::ST_STALE;
        end else begin
          status_nxt = gvsp_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= '0;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    alive_r  <= alive_nxt;
    freed_r  <= freed_nxt;
    if (go) live_out_r <= live_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.handle_out  = hout_r;
  assign out_ch.alive       = alive_r;
  assign out_ch.freed_count = freed_r;
  assign out_ch.live_count  = live_out_r;

endmodule
